/* rtl/xsis_pkg.sv */
// Package for the x86 string instruction step unit.
// Holds the command and result word types, opcode and prefix codes, and FLAGS bit positions.
// No dependencies.
package xsis_pkg;

	localparam int unsigned DataW = 16;

	// Opcodes: byte forms, then word forms in the same order
	localparam logic [3:0] OP_MOVSB = 4'd0;
	localparam logic [3:0] OP_CMPSB = 4'd1;
	localparam logic [3:0] OP_STOSB = 4'd2;
	localparam logic [3:0] OP_LODSB = 4'd3;
	localparam logic [3:0] OP_SCASB = 4'd4;
	localparam logic [3:0] OP_MOVSW = 4'd5;
	localparam logic [3:0] OP_CMPSW = 4'd6;
	localparam logic [3:0] OP_STOSW = 4'd7;
	localparam logic [3:0] OP_LODSW = 4'd8;
	localparam logic [3:0] OP_SCASW = 4'd9;

	// Repeat prefixes
	localparam logic [1:0] REP_NONE  = 2'd0;
	localparam logic [1:0] REP_REPE  = 2'd1;
	localparam logic [1:0] REP_REPNE = 2'd2;

	// FLAGS bit positions
	localparam int unsigned FLAG_CF = 0;
	localparam int unsigned FLAG_PF = 2;
	localparam int unsigned FLAG_AF = 4;
	localparam int unsigned FLAG_ZF = 6;
	localparam int unsigned FLAG_SF = 7;
	localparam int unsigned FLAG_DF = 10;
	localparam int unsigned FLAG_OF = 11;

	typedef enum logic [2:0] {
		KIND_MOVS,
		KIND_CMPS,
		KIND_STOS,
		KIND_LODS,
		KIND_SCAS,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		logic [3:0]       op;
		logic [1:0]       rep_mode;
		logic [DataW-1:0] count_reg;
		logic [DataW-1:0] source_index;
		logic [DataW-1:0] dest_index;
		logic [DataW-1:0] accumulator;
		logic [DataW-1:0] flags_in;
		logic [DataW-1:0] source_segment;
		logic [DataW-1:0] dest_segment;
		logic [DataW-1:0] source_data;
		logic [DataW-1:0] dest_data;
	} cmd_t;

	typedef struct packed {
		logic             skipped;
		logic             needs_source_read;
		logic             needs_dest_read;
		logic             write_enable;
		logic [DataW-1:0] write_data;
		logic [DataW-1:0] count_out;
		logic [DataW-1:0] source_index_out;
		logic [DataW-1:0] dest_index_out;
		logic [DataW-1:0] accumulator_out;
		logic [DataW-1:0] flags_out;
		logic             repeat_again;
	} rsp_t;

endpackage

/* rtl/xsis_flags.sv */
// Compare flag unit: CF, PF, AF, ZF, SF and OF of a byte or word subtract a - b.
// Depends on xsis_pkg.
module xsis_flags (
	input  logic [xsis_pkg::DataW-1:0] a,
	input  logic [xsis_pkg::DataW-1:0] b,
	input  logic                       word,
	input  logic [xsis_pkg::DataW-1:0] flags_in,
	output logic [xsis_pkg::DataW-1:0] flags_out
);
	import xsis_pkg::*;

	logic [DataW-1:0] diff;
	logic [DataW-1:0] mix;
	logic             cf, zf, sf, of;

	assign diff = a - b;
	assign mix  = (a ^ b) & (a ^ diff);

	always_comb begin
		if (word) begin
			cf = a < b;
			zf = diff == '0;
			sf = diff[15];
			of = mix[15];
		end else begin
			cf = a[7:0] < b[7:0];
			zf = diff[7:0] == 8'h00;
			sf = diff[7];
			of = mix[7];
		end
	end

	always_comb begin
		flags_out          = flags_in;
		flags_out[FLAG_CF] = cf;
		flags_out[FLAG_PF] = ~^diff[7:0];
		flags_out[FLAG_AF] = a[4] ^ b[4] ^ diff[4];
		flags_out[FLAG_ZF] = zf;
		flags_out[FLAG_SF] = sf;
		flags_out[FLAG_OF] = of;
	end

endmodule

/* rtl/xsis_exec.sv */
// Single-pass execution of one string instruction iteration.
// Depends on xsis_pkg and xsis_flags.
module xsis_exec (
	input  xsis_pkg::cmd_t cmd,
	output xsis_pkg::rsp_t rsp
);
	import xsis_pkg::*;

	kind_t            kind;
	logic             word;
	logic             repeated;
	logic             skip;
	logic             active;
	logic [DataW-1:0] step;
	logic [DataW-1:0] si_next;
	logic [DataW-1:0] di_next;
	logic [DataW-1:0] cx_dec;
	logic [DataW-1:0] cmp_a;
	logic [DataW-1:0] cmp_flags;
	logic             zf;
	logic             stop_ok;

	always_comb begin
		unique case (cmd.op)
			OP_MOVSB, OP_MOVSW: kind = KIND_MOVS;
			OP_CMPSB, OP_CMPSW: kind = KIND_CMPS;
			OP_STOSB, OP_STOSW: kind = KIND_STOS;
			OP_LODSB, OP_LODSW: kind = KIND_LODS;
			OP_SCASB, OP_SCASW: kind = KIND_SCAS;
			default:            kind = KIND_NONE;
		endcase
	end

	assign word     = cmd.op >= OP_MOVSW;
	assign repeated = cmd.rep_mode != REP_NONE;
	assign skip     = (kind != KIND_NONE) && repeated && (cmd.count_reg == '0);
	assign active   = (kind != KIND_NONE) && !skip;

	// Step of 1 or 2, negated when DF is set
	always_comb begin
		unique case ({cmd.flags_in[FLAG_DF], word})
			2'b00:   step = DataW'(1);
			2'b01:   step = DataW'(2);
			2'b10:   step = {DataW{1'b1}};
			default: step = {{(DataW-2){1'b1}}, 2'b10};
		endcase
	end

	assign si_next = cmd.source_index + step;
	assign di_next = cmd.dest_index + step;
	assign cx_dec  = cmd.count_reg - DataW'(1);
	assign cmp_a   = (kind == KIND_CMPS) ? cmd.source_data : cmd.accumulator;

	xsis_flags u_flags (
		.a         (cmp_a),
		.b         (cmd.dest_data),
		.word      (word),
		.flags_in  (cmd.flags_in),
		.flags_out (cmp_flags)
	);

	assign zf      = cmp_flags[FLAG_ZF];
	assign stop_ok = (cmd.rep_mode == REP_REPE) ? zf : !zf;

	always_comb begin
		rsp                   = '0;
		rsp.skipped           = skip;
		rsp.count_out         = cmd.count_reg;
		rsp.source_index_out  = cmd.source_index;
		rsp.dest_index_out    = cmd.dest_index;
		rsp.accumulator_out   = cmd.accumulator;
		rsp.flags_out         = cmd.flags_in;
		if (active) begin
			unique case (kind)
				KIND_MOVS: begin
					rsp.needs_source_read = 1'b1;
					rsp.write_enable      = 1'b1;
					rsp.write_data        = word ? cmd.source_data
					                             : {8'h00, cmd.source_data[7:0]};
					rsp.source_index_out  = si_next;
					rsp.dest_index_out    = di_next;
				end
				KIND_CMPS: begin
					rsp.needs_source_read = 1'b1;
					rsp.needs_dest_read   = 1'b1;
					rsp.flags_out         = cmp_flags;
					rsp.source_index_out  = si_next;
					rsp.dest_index_out    = di_next;
				end
				KIND_STOS: begin
					rsp.write_enable   = 1'b1;
					rsp.write_data     = word ? cmd.accumulator
					                          : {8'h00, cmd.accumulator[7:0]};
					rsp.dest_index_out = di_next;
				end
				KIND_LODS: begin
					rsp.needs_source_read = 1'b1;
					rsp.accumulator_out   = word ? cmd.source_data
					                             : {cmd.accumulator[15:8],
					                                cmd.source_data[7:0]};
					rsp.source_index_out  = si_next;
				end
				KIND_SCAS: begin
					rsp.needs_dest_read = 1'b1;
					rsp.flags_out       = cmp_flags;
					rsp.dest_index_out  = di_next;
				end
				default: begin
				end
			endcase
			if (repeated) begin
				rsp.count_out    = cx_dec;
				rsp.repeat_again = (cx_dec != '0) &&
				                   (((kind != KIND_CMPS) && (kind != KIND_SCAS)) || stop_ok);
			end
		end
	end

endmodule

/* rtl/x86_string_instruction_step_unit.sv */
// Top level of the x86 string instruction step unit.
// Depends on xsis_pkg and xsis_exec.
//
// One iteration of an 8086 string instruction (MOVS, CMPS, STOS, LODS, SCAS, byte or
// word) per command word. A word is taken at every rising edge where start is high;
// busy is always low, so a new word may follow in every cycle. The word is captured
// in an input register, executed by one pass of combinational logic, and the result
// word sits in an output register: done follows start through the input register and
// the output register and is high for exactly one cycle, with the result word held in
// the output register. The result ports are valid in that cycle only. The receiver
// cannot stall, so take the result when done is high. A repeated run entered with CX
// zero comes back with skipped set and all registers unchanged. Segment values ride
// along but do not affect the result; IP rewind on repeat_again is up to the sequencer.
module x86_string_instruction_step_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  xsis_pkg::cmd_t item,
	output logic           done,
	output xsis_pkg::rsp_t result
);
	import xsis_pkg::*;

	cmd_t item_s1;
	logic valid_s1;
	rsp_t rsp_comb;
	rsp_t result_s2;
	logic done_s2;

	// Never stall the command side
	assign busy = 1'b0;

	// Input register: capture the command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= item;
		end
	end

	xsis_exec u_exec (
		.cmd (item_s1),
		.rsp (rsp_comb)
	);

	// Output register: hold the result word for its single strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= rsp_comb;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

/* rtl/xsis_checker.sv */
// Port-level checker for the x86 string instruction step unit, and its bind.
// Depends on xsis_pkg and x86_string_instruction_step_unit.
module xsis_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input xsis_pkg::rsp_t result,
	input logic           done
);
	import xsis_pkg::*;

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted word produced no result");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without a matching command word");

	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.skipped |-> !result.write_enable && !result.repeat_again &&
		!result.needs_source_read && !result.needs_dest_read)
		else $error("skipped run touched memory or repeated");

	a_again_cx: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.repeat_again |-> result.count_out != '0)
		else $error("repeat requested with CX zero");

	a_wdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.write_enable |-> result.write_data == '0)
		else $error("write data nonzero without a write");

endmodule

bind x86_string_instruction_step_unit xsis_checker u_xsis_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.done   (done)
);

/* sim/testbench.sv */
// Self-checking testbench for x86_string_instruction_step_unit.
// Depends on xsis_pkg and the unit's RTL. It drives command words from a queue and
// checks each result word against a local model of one 8086 string iteration.
module testbench;
	import xsis_pkg::*;

	// One queued command word. settle_first holds the word back until every
	// earlier result word has come back.
	typedef struct {
		cmd_t cmd;
		bit   settle_first;
	} queued_word_t;

	localparam int unsigned WordTarget = 1550;
	localparam int unsigned IdleLimit  = 2000;
	localparam int unsigned TailCycles = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t item = '0;
	logic busy;
	logic done;
	rsp_t result;

	queued_word_t pending_words[$];
	rsp_t         expected_results[$];
	int unsigned  results_owed = 0;
	int unsigned  words_sent = 0;
	int unsigned  total_words = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  errors = 0;
	int unsigned  results_checked = 0;
	int unsigned  skips_seen = 0;
	int unsigned  repeats_seen = 0;

	x86_string_instruction_step_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Flags of an 8086 SUB a - b: rewrite CF, PF, AF, ZF, SF, OF and keep the rest.
	function automatic logic [15:0] compare_flags(logic [15:0] a, logic [15:0] b, bit wide,
			logic [15:0] fl);
		logic [16:0] diff;
		logic [15:0] r;
		int          top;
		logic [15:0] f;
		if (!wide) begin
			a[15:8] = 8'h00;
			b[15:8] = 8'h00;
		end
		diff = {1'b0, a} - {1'b0, b};
		r = wide ? diff[15:0] : {8'h00, diff[7:0]};
		top = wide ? 15 : 7;
		f = fl;
		f[FLAG_CF] = a < b;
		f[FLAG_PF] = ~^r[7:0];
		f[FLAG_AF] = a[4] ^ b[4] ^ r[4];
		f[FLAG_ZF] = r == 16'h0000;
		f[FLAG_SF] = r[top];
		f[FLAG_OF] = (a[top] ^ b[top]) & (a[top] ^ r[top]);
		return f;
	endfunction

	// Work out the result word of one string iteration.
	function automatic rsp_t run_string_step(cmd_t c);
		rsp_t        r;
		kind_t       kind;
		logic [3:0]  kind_code;
		bit          wide;
		bit          watch_zf;
		logic [15:0] stride;
		r = '0;
		r.count_out = c.count_reg;
		r.source_index_out = c.source_index;
		r.dest_index_out = c.dest_index;
		r.accumulator_out = c.accumulator;
		r.flags_out = c.flags_in;
		watch_zf = 1'b0;
		// unused opcodes pass everything through
		if (c.op > OP_SCASW)
			return r;
		wide = c.op >= OP_MOVSW;
		kind_code = wide ? c.op - OP_MOVSW : c.op;
		kind = kind_t'(kind_code[2:0]);
		stride = wide ? 16'd2 : 16'd1;
		if (c.flags_in[FLAG_DF])
			stride = -stride;
		// repeated run entered with CX zero touches nothing
		if (c.rep_mode != REP_NONE && c.count_reg == 16'h0000) begin
			r.skipped = 1'b1;
			return r;
		end
		case (kind)
			KIND_MOVS: begin
				r.needs_source_read = 1'b1;
				r.write_enable = 1'b1;
				r.write_data = wide ? c.source_data : {8'h00, c.source_data[7:0]};
				r.source_index_out = c.source_index + stride;
				r.dest_index_out = c.dest_index + stride;
			end
			KIND_CMPS: begin
				r.needs_source_read = 1'b1;
				r.needs_dest_read = 1'b1;
				r.flags_out = compare_flags(c.source_data, c.dest_data, wide, c.flags_in);
				r.source_index_out = c.source_index + stride;
				r.dest_index_out = c.dest_index + stride;
				watch_zf = 1'b1;
			end
			KIND_STOS: begin
				r.write_enable = 1'b1;
				r.write_data = wide ? c.accumulator : {8'h00, c.accumulator[7:0]};
				r.dest_index_out = c.dest_index + stride;
			end
			KIND_LODS: begin
				r.needs_source_read = 1'b1;
				r.accumulator_out = wide ? c.source_data
					: {c.accumulator[15:8], c.source_data[7:0]};
				r.source_index_out = c.source_index + stride;
			end
			KIND_SCAS: begin
				r.needs_dest_read = 1'b1;
				r.flags_out = compare_flags(c.accumulator, c.dest_data, wide, c.flags_in);
				r.dest_index_out = c.dest_index + stride;
				watch_zf = 1'b1;
			end
			default: begin
			end
		endcase
		if (c.rep_mode != REP_NONE) begin
			r.count_out = c.count_reg - 16'd1;
			if (r.count_out != 16'h0000) begin
				// REPE continues on equal; REPNE and the spare code on unequal
				if (!watch_zf)
					r.repeat_again = 1'b1;
				else if (c.rep_mode == REP_REPE)
					r.repeat_again = r.flags_out[FLAG_ZF];
				else
					r.repeat_again = !r.flags_out[FLAG_ZF];
			end
		end
		return r;
	endfunction

	// Favor the wrap points of a 16-bit register.
	function automatic logic [15:0] corner16();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001;
			3: return 16'hFFFE;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_t random_word(logic [3:0] op, logic [1:0] rep, logic [15:0] cx,
			bit df);
		cmd_t c;
		c.op = op;
		c.rep_mode = rep;
		c.count_reg = cx;
		c.source_index = corner16();
		c.dest_index = corner16();
		c.accumulator = 16'($urandom);
		c.flags_in = 16'($urandom);
		c.flags_in[FLAG_DF] = df;
		c.source_segment = 16'($urandom);
		c.dest_segment = 16'($urandom);
		c.source_data = 16'($urandom);
		c.dest_data = 16'($urandom);
		return c;
	endfunction

	// Make the compared operands equal (or leave them random) so ZF goes both ways.
	function automatic cmd_t with_match(cmd_t c, bit same);
		if (same) begin
			c.dest_data = (c.op == OP_SCASB || c.op == OP_SCASW) ? c.accumulator
				: c.source_data;
			if (c.op < OP_MOVSW)
				c.dest_data[15:8] = 8'($urandom);
		end
		return c;
	endfunction

	task automatic queue_word(cmd_t c, bit settle);
		queued_word_t q;
		q.cmd = c;
		q.settle_first = settle;
		pending_words.push_back(q);
	endtask

	// Compare one field and report the difference.
	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Driver: advance the queue on each accepted word, then pick the next word or a gap.
	always @(posedge clk or negedge arst_n) begin : drive_words
		bit          took;
		int unsigned gap_pct;
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			words_sent <= 0;
		end else begin
			took = start && !busy;
			if (took) begin
				void'(pending_words.pop_front());
				words_sent <= words_sent + 1;
			end
			// idle profile by thirds: light gaps, heavy gaps, back to back
			if (words_sent < total_words / 3)
				gap_pct = 8;
			else if (words_sent < 2 * total_words / 3)
				gap_pct = 52;
			else
				gap_pct = 0;
			if (pending_words.size() == 0) begin
				start <= 1'b0;
			end else if (pending_words[0].settle_first && (took || results_owed != 0)) begin
				// hold until every result word in flight has come back
				start <= 1'b0;
			end else if ($urandom_range(99) < gap_pct) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				item <= pending_words[0].cmd;
			end
		end
	end

	// Monitor: check result words, record expectations for accepted command words,
	// and watch for a stall.
	always @(posedge clk or negedge arst_n) begin : watch_results
		rsp_t want;
		if (!arst_n) begin
			results_owed <= 0;
			idle_cycles <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, got %h",
						$time, result);
				end else begin
					want = expected_results.pop_front();
					check_field("skipped", 16'(want.skipped), 16'(result.skipped));
					check_field("needs_source_read", 16'(want.needs_source_read),
						16'(result.needs_source_read));
					check_field("needs_dest_read", 16'(want.needs_dest_read),
						16'(result.needs_dest_read));
					check_field("write_enable", 16'(want.write_enable),
						16'(result.write_enable));
					check_field("write_data", want.write_data, result.write_data);
					check_field("count_out", want.count_out, result.count_out);
					check_field("source_index_out", want.source_index_out,
						result.source_index_out);
					check_field("dest_index_out", want.dest_index_out,
						result.dest_index_out);
					check_field("accumulator_out", want.accumulator_out,
						result.accumulator_out);
					check_field("flags_out", want.flags_out, result.flags_out);
					check_field("repeat_again", 16'(want.repeat_again),
						16'(result.repeat_again));
					results_checked++;
					if (want.skipped)
						skips_seen++;
					if (want.repeat_again)
						repeats_seen++;
				end
			end
			if (start && !busy)
				expected_results.push_back(run_string_step(item));
			results_owed <= expected_results.size();
			if ((start && !busy) || done === 1'b1) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IdleLimit) begin
				$display("%0t: no word moved for %0d cycles", $time, IdleLimit);
				$display("testbench NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		cmd_t        c;
		rsp_t        r;
		logic [3:0]  op;
		logic [1:0]  rep;
		int unsigned steps;

		// Directed: every opcode once without a prefix, DF alternating
		for (int k = 0; k <= int'(OP_SCASW); k++)
			queue_word(random_word(4'(k), REP_NONE, 16'($urandom), k[0]), 1'b0);

		// skipped runs with CX zero
		queue_word(random_word(OP_MOVSB, REP_REPE, 16'h0000, 1'b0), 1'b0);
		queue_word(random_word(OP_CMPSW, REP_REPE, 16'h0000, 1'b1), 1'b1);
		// last iteration; DI wraps upward
		c = random_word(OP_STOSW, REP_REPE, 16'h0001, 1'b0);
		c.dest_index = 16'hFFFF;
		queue_word(c, 1'b0);
		// largest count, SI wraps downward, AH kept
		c = random_word(OP_LODSB, REP_REPNE, 16'hFFFF, 1'b1);
		c.source_index = 16'h0000;
		queue_word(c, 1'b0);
		// REPE compare equal keeps going; REPNE compare equal stops
		queue_word(with_match(random_word(OP_CMPSB, REP_REPE, 16'd5, 1'b0), 1'b1), 1'b0);
		queue_word(with_match(random_word(OP_CMPSB, REP_REPNE, 16'd5, 1'b1), 1'b1), 1'b0);
		c = random_word(OP_SCASW, REP_REPNE, 16'd2, 1'b0);
		c.dest_data = ~c.accumulator;
		queue_word(c, 1'b0);
		// spare prefix code acts as REPNE
		queue_word(with_match(random_word(OP_SCASB, 2'd3, 16'd3, 1'b1), 1'b1), 1'b0);
		// REPNE on a move behaves like REP
		queue_word(random_word(OP_MOVSW, REP_REPNE, 16'd2, 1'b1), 1'b0);
		// unused opcode under a prefix with CX zero does nothing, not even skip
		queue_word(random_word(4'd15, REP_REPE, 16'h0000, 1'b0), 1'b0);
		// signed overflow on a word compare, all flags set going in
		c = random_word(OP_CMPSW, REP_NONE, 16'd7, 1'b1);
		c.flags_in = 16'hFFFF;
		c.source_data = 16'h8000;
		c.dest_data = 16'h0001;
		queue_word(c, 1'b0);
		// borrow on a byte scan, all flags clear going in
		c = random_word(OP_SCASB, REP_NONE, 16'd7, 1'b0);
		c.flags_in = 16'h0000;
		c.accumulator = 16'hFF00;
		c.dest_data = 16'h0001;
		queue_word(c, 1'b0);

		// Random: mostly runs that feed each result back as the next word, some noise
		while (pending_words.size() < WordTarget) begin
			if ($urandom_range(9) < 7) begin
				op = 4'($urandom_range(int'(OP_SCASW)));
				rep = 2'($urandom_range(3, 1));
				c = random_word(op, rep, ($urandom_range(19) == 0) ? 16'hFFFF
					: 16'($urandom_range(12, 1)), 1'($urandom_range(1)));
				steps = 0;
				do begin
					c = with_match(c, (rep == REP_REPE) ? ($urandom_range(4) != 0)
						: ($urandom_range(4) == 0));
					queue_word(c, $urandom_range(79) == 0);
					r = run_string_step(c);
					c.count_reg = r.count_out;
					c.source_index = r.source_index_out;
					c.dest_index = r.dest_index_out;
					c.accumulator = r.accumulator_out;
					c.flags_in = r.flags_out;
					c.source_data = 16'($urandom);
					c.dest_data = 16'($urandom);
					steps++;
				end while (r.repeat_again && steps < 16);
			end else begin
				op = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 10))
					: 4'($urandom_range(int'(OP_SCASW)));
				case ($urandom_range(9))
					0: c = random_word(op, 2'($urandom_range(3)), 16'h0000, 1'($urandom));
					1: c = random_word(op, 2'($urandom_range(3)), 16'h0001, 1'($urandom));
					2: c = random_word(op, 2'($urandom_range(3)), 16'hFFFF, 1'($urandom));
					default: c = random_word(op, 2'($urandom_range(3)), 16'($urandom),
						1'($urandom));
				endcase
				queue_word(with_match(c, 1'($urandom)), $urandom_range(79) == 0);
			end
		end
		total_words = pending_words.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: all words sent, all results back, then a short tail
		do
			@(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0 || start);
		repeat (TailCycles) @(negedge clk);

		$display("Checked %0d result words: %0d skipped runs, %0d continuing repeats,",
			results_checked, skips_seen, repeats_seen);
		$display("over light, heavy and no sender gaps; %0d errors", errors);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
